@@ rtl/cel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cel_pkg: shared types and constants of the compacting element list
// Sizes of the element store, the stream payload layout, command and
// status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package cel_pkg;

  // Element store geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ELEM_W = 32;

  // Stream payload widths
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int IN_BITS    = CMD_W + ELEM_W + ADDR_W;
  localparam int OUT_BITS   = ELEM_W + CNT_W + STAT_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RDWAIT,
    S_SHIFT,
    S_EMIT
  } state_t;

endpackage

@@ rtl/compacting_element_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_element_list: ordered list with delete compaction
// An ordered list of DEPTH elements held in one synchronous RAM. Append
// adds at the tail, read returns an element, remove deletes one and moves
// every later element down a place.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per accepted beat (cmd, value, index in in_tdata).
//   out_* : one result per request (read_data, count, status), in order.
//   The output register lets a new request be taken while a result waits.
// Sequencing / throughput, set by the single-port-per-direction element RAM:
//   append, unused command, and any rejected request: result registered in
//   the accept cycle, so one request per cycle while out_tready is high.
//   read: RAM address in the accept cycle, registered read data, result (S_RDWAIT, S_EMIT).
//   remove at index i: the shift loop moves one element per cycle (read one
//   entry, write the one below), then the result is emitted.
// Reset (synchronous, rst_n low): list empties, no result pending. RAM
//   contents are not cleared; entries at or above the length are never used.
// Stall: while out_tready is low a finished result is held; one further
//   request may complete into a holding register, then in_tready drops.
// ----------------------------------------------------------------------------
module compacting_element_list
  import cel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // cmd[1:0], value[33:2], index[39:34]
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // read_data[31:0], count[38:32], status[40:39]
);

  // Request fields
  cmd_t              in_cmd;
  logic [ELEM_W-1:0] in_value;
  logic [ADDR_W-1:0] in_index;

  assign in_cmd   = cmd_t'(in_tdata[CMD_W-1:0]);
  assign in_value = in_tdata[CMD_W +: ELEM_W];
  assign in_index = in_tdata[CMD_W+ELEM_W +: ADDR_W];

  // Element RAM
  logic [ELEM_W-1:0] mem [DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [ELEM_W-1:0] mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  logic [ELEM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // Control and payload registers
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic [ELEM_W-1:0]  res_data_r, res_data_nxt;
  status_t            res_stat_r, res_stat_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0] out_data_r, out_data_nxt;

  logic               accept;
  logic               out_free;
  logic               idx_bad;
  logic               full;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign idx_bad  = {1'b0, in_index} >= count_r;
  assign full     = count_r == CNT_W'(DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    wr_addr_r  <= wr_addr_nxt;
    res_data_r <= res_data_nxt;
    res_stat_r <= res_stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_nxt      = pend_r;
    wr_addr_nxt   = wr_addr_r;
    res_data_nxt  = res_data_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = wr_addr_r;
    mem_wd        = rdata_r;
    mem_ra        = rd_ptr_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        mem_ra    = in_index;
        if (accept) begin
          res_data_nxt = '0;
          res_stat_nxt = ST_OK;
          unique case (in_cmd)
            CMD_APPEND: begin
              if (full) begin
                res_stat_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = count_r[ADDR_W-1:0];
                mem_wd    = in_value;
                count_nxt = count_r + 1'b1;
              end
            end
            CMD_READ: begin
              if (idx_bad) begin
                res_stat_nxt = ST_RANGE;
              end else begin
                state_nxt = S_RDWAIT;
              end
            end
            CMD_REMOVE: begin
              if (idx_bad) begin
                res_stat_nxt = ST_RANGE;
              end else begin
                rd_ptr_nxt = {1'b0, in_index} + 1'b1;
                pend_nxt   = 1'b0;
                state_nxt  = S_SHIFT;
              end
            end
            CMD_NOP: begin
            end
            default: begin
            end
          endcase
          // immediate results go straight to the output register when free
          if (state_nxt == S_IDLE) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = {res_stat_nxt, count_nxt, res_data_nxt};
            end else begin
              state_nxt = S_EMIT;
            end
          end
        end
      end

      S_RDWAIT: begin
        res_data_nxt = rdata_r;
        state_nxt    = S_EMIT;
      end

      // read entry rd_ptr, write the previously read entry one place lower
      S_SHIFT: begin
        if (pend_r) begin
          mem_we = 1'b1;
        end
        if (rd_ptr_r < count_r) begin
          pend_nxt    = 1'b1;
          wr_addr_nxt = ADDR_W'(rd_ptr_r - 1'b1);
          rd_ptr_nxt  = rd_ptr_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          count_nxt = count_r - 1'b1;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_stat_r, count_r, res_data_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_data_r};

endmodule

@@ rtl/cel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cel_checker: port-level checks for the compacting element list
// Watches the result channel for legal counts, status codes and holds.
// ----------------------------------------------------------------------------
module cel_checker
  import cel_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic [CNT_W-1:0]  res_count;
  logic [STAT_W-1:0] res_stat;
  logic [ELEM_W-1:0] res_data;

  assign res_data  = out_tdata[ELEM_W-1:0];
  assign res_count = out_tdata[ELEM_W +: CNT_W];
  assign res_stat  = out_tdata[ELEM_W+CNT_W +: STAT_W];

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // length never exceeds capacity
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_count <= CNT_W'(DEPTH))
    else $error("count beyond capacity");

  // failed requests return no data and a known status
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_stat == ST_OK || res_stat == ST_FULL || res_stat == ST_RANGE) &&
                   (res_stat == ST_OK || res_data == '0))
    else $error("bad status or data on failed request");

  // a full status only reports a full list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_stat == ST_FULL |-> res_count == CNT_W'(DEPTH))
    else $error("full status with room left");

endmodule

bind compacting_element_list cel_checker u_cel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
